@@ rtl/core/dema_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dema_pkg: shared types and constants of the debiased ema smoother
// Fixed-point widths, queue entry layout and saturation bounds.
// ----------------------------------------------------------------------------
package dema_pkg;

	// sample and weight formats
	localparam int SAMPLE_W = 32;               // signed Q16.16 sample
	localparam int WFB      = 16;               // weight fraction bits
	localparam int W_W      = WFB + 1;          // weight register width
	localparam int ACC_W    = SAMPLE_W + WFB;   // accumulator width
	localparam int P_FRAC   = 32;               // power fraction bits
	localparam int P_W      = P_FRAC + 1;       // power width, Q1.32

	// product widths
	localparam int PROD_ACC_W = ACC_W + W_W;
	localparam int PROD_X_W   = SAMPLE_W + WFB;
	localparam int PROD_P_W   = P_W + W_W;

	// divider geometry
	localparam int NUM_W     = ACC_W + P_FRAC - WFB;
	localparam int DIV_STEPS = SAMPLE_W - 1;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [W_W-1:0] W_ONE = {1'b1, {WFB{1'b0}}};
	localparam logic [P_W-1:0] P_ONE = {1'b1, {P_FRAC{1'b0}}};

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic [ACC_W-1:0]    ACC_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0]    ACC_MIN    = {1'b1, {(ACC_W-1){1'b0}}};

	// what the back end has to do with a queued item
	typedef enum logic [1:0] {
		KIND_PASS   = 2'd0,
		KIND_DIRECT = 2'd1,
		KIND_DIVIDE = 2'd2
	} item_kind_t;

	// queued item: accumulator (or raw sample for pass) and debias divisor
	typedef struct packed {
		item_kind_t        kind;
		logic [ACC_W-1:0]  acc;
		logic [P_W-1:0]    denom;
	} queue_entry_t;

endpackage

@@ rtl/core/dema_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dema_front: input side of the smoother
// Holds the weight, the average and the weight power, classifies each beat
// and pushes the updated state or the raw sample into the queue.
// ----------------------------------------------------------------------------
module dema_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [dema_pkg::W_W-1:0]            cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [dema_pkg::SAMPLE_W-1:0] in_value,
	input  logic                                in_invalid,
	input  logic                                in_constant,
	output logic                                q_push,
	output dema_pkg::queue_entry_t              q_entry,
	input  logic                                q_full
);

	localparam logic [dema_pkg::PROD_ACC_W-1:0] RND_ACC =
		{{(dema_pkg::PROD_ACC_W-dema_pkg::WFB){1'b0}}, 1'b1, {(dema_pkg::WFB-1){1'b0}}};
	localparam logic [dema_pkg::PROD_P_W-1:0] RND_P =
		{{(dema_pkg::PROD_P_W-dema_pkg::WFB){1'b0}}, 1'b1, {(dema_pkg::WFB-1){1'b0}}};

	logic [dema_pkg::W_W-1:0]              weight_q;
	logic [dema_pkg::W_W-1:0]              cfg_weight;
	logic [dema_pkg::W_W-1:0]              om_w;
	logic signed [dema_pkg::ACC_W-1:0]     acc_q;
	logic [dema_pkg::P_W-1:0]              pow_q;
	logic                                  accept;

	logic signed [dema_pkg::PROD_ACC_W-1:0] prod_acc;
	logic signed [dema_pkg::PROD_X_W-1:0]   prod_x;
	logic [dema_pkg::PROD_P_W-1:0]          prod_p;

	logic                                   valid_s1;
	logic                                   pass_s1;
	logic                                   direct_s1;
	logic [dema_pkg::SAMPLE_W-1:0]          x_s1;
	logic [dema_pkg::PROD_ACC_W-1:0]        prod_acc_s1;
	logic [dema_pkg::PROD_X_W-1:0]          prod_x_s1;
	logic [dema_pkg::PROD_P_W-1:0]          prod_p_s1;

	logic [dema_pkg::PROD_ACC_W-1:0]        acc_rnd;
	logic [dema_pkg::ACC_W+1:0]             acc_sum;
	logic [dema_pkg::ACC_W-1:0]             acc_new;
	logic [dema_pkg::PROD_P_W-1:0]          pow_rnd;
	logic [dema_pkg::P_W-1:0]               pow_new;
	logic                                   do_divide;

	// weight writes above one clamp to one
	assign cfg_weight = (cfg_wr_data > dema_pkg::W_ONE) ? dema_pkg::W_ONE : cfg_wr_data;

	// one beat in flight through the update stage at a time
	assign in_ready = !valid_s1 && !q_full;
	assign accept   = in_valid && in_ready;

	// stage 1 multipliers, fed from state and the incoming sample
	assign om_w     = dema_pkg::W_ONE - weight_q;
	assign prod_acc = acc_q * $signed({1'b0, weight_q});
	assign prod_x   = in_value * $signed({1'b0, om_w[dema_pkg::WFB-1:0]});
	assign prod_p   = dema_pkg::PROD_P_W'(pow_q) * dema_pkg::PROD_P_W'(weight_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && (weight_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pass_s1     <= in_invalid || in_constant;
			direct_s1   <= (weight_q == dema_pkg::W_ONE);
			x_s1        <= in_value;
			prod_acc_s1 <= prod_acc;
			prod_x_s1   <= prod_x;
			prod_p_s1   <= prod_p;
		end
	end

	// stage 2: round, accumulate, saturate
	always_comb begin
		acc_rnd = prod_acc_s1 + RND_ACC;
		acc_sum = {acc_rnd[dema_pkg::PROD_ACC_W-1], acc_rnd[dema_pkg::PROD_ACC_W-1:dema_pkg::WFB]}
			+ {{2{prod_x_s1[dema_pkg::PROD_X_W-1]}}, prod_x_s1};
		if (acc_sum[dema_pkg::ACC_W+1:dema_pkg::ACC_W-1] == 3'b000 ||
			acc_sum[dema_pkg::ACC_W+1:dema_pkg::ACC_W-1] == 3'b111) begin
			acc_new = acc_sum[dema_pkg::ACC_W-1:0];
		end else if (acc_sum[dema_pkg::ACC_W+1]) begin
			acc_new = dema_pkg::ACC_MIN;
		end else begin
			acc_new = dema_pkg::ACC_MAX;
		end
		pow_rnd   = prod_p_s1 + RND_P;
		pow_new   = pow_rnd[dema_pkg::WFB+dema_pkg::P_W-1:dema_pkg::WFB];
		do_divide = !direct_s1 && !pow_new[dema_pkg::P_W-1];
	end

	// queue entry
	always_comb begin
		q_push        = valid_s1;
		q_entry.denom = dema_pkg::P_ONE - pow_new;
		if (pass_s1) begin
			q_entry.kind = dema_pkg::KIND_PASS;
			q_entry.acc  = dema_pkg::ACC_W'(signed'(x_s1));
		end else begin
			q_entry.kind = do_divide ? dema_pkg::KIND_DIVIDE : dema_pkg::KIND_DIRECT;
			q_entry.acc  = acc_new;
		end
	end

	// state: updated by smoothed beats, cleared by a weight change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= '0;
			acc_q    <= '0;
			pow_q    <= dema_pkg::P_ONE;
		end else begin
			if (valid_s1 && !pass_s1) begin
				acc_q <= acc_new;
				pow_q <= pow_new;
			end
			if (cfg_wr_en && (cfg_weight != weight_q)) begin
				weight_q <= cfg_weight;
				acc_q    <= '0;
				pow_q    <= dema_pkg::P_ONE;
			end
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into a full queue");

	a_accept_push: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (weight_q != '0)) |=> q_push)
		else $error("accepted beat not pushed");

endmodule

@@ rtl/core/dema_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dema_queue: short queue between front and back
// Register array with read and write pointers and an occupancy count.
// ----------------------------------------------------------------------------
module dema_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  dema_pkg::queue_entry_t push_entry,
	output logic                   full,
	input  logic                   pop,
	output dema_pkg::queue_entry_t pop_entry,
	output logic                   empty
);

	dema_pkg::queue_entry_t          mem_q [dema_pkg::QUEUE_DEPTH];
	logic [dema_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [dema_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [dema_pkg::QCNT_W-1:0]     count_q;

	assign full      = (count_q == dema_pkg::QCNT_W'(dema_pkg::QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign pop_entry = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == dema_pkg::QPTR_W'(dema_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == dema_pkg::QPTR_W'(dema_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/dema_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dema_back: output side of the smoother
// Pops queued beats, debiases through a bit-serial divider or rounds the
// average directly, and holds the result in the output register.
// ----------------------------------------------------------------------------
module dema_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dema_pkg::queue_entry_t        q_entry,
	input  logic                          q_empty,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dema_pkg::SAMPLE_W-1:0] out_value,
	output logic                          out_smoothed
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} back_state_t;

	localparam logic [dema_pkg::ACC_W:0] RND_OUT =
		{{(dema_pkg::ACC_W+1-dema_pkg::WFB){1'b0}}, 1'b1, {(dema_pkg::WFB-1){1'b0}}};
	localparam int REM_W = dema_pkg::NUM_W - dema_pkg::DIV_STEPS;

	back_state_t                        state_q, state_d;
	logic                               neg_q;
	logic [dema_pkg::ACC_W-1:0]         mag_q;
	logic [dema_pkg::P_W-1:0]           denom_q;
	logic [dema_pkg::P_W-1:0]           rem_q;
	logic [dema_pkg::DIV_STEPS-1:0]     num_lo_q;
	logic [dema_pkg::DIV_STEPS-1:0]     quo_q;
	logic [dema_pkg::CNT_W-1:0]         cnt_q;
	logic                               ovf_q;

	logic                               out_valid_q;
	logic [dema_pkg::SAMPLE_W-1:0]      out_value_q;
	logic                               out_smoothed_q;

	logic                               out_free;
	logic                               write_out;
	logic [dema_pkg::SAMPLE_W-1:0]      new_value;
	logic                               new_smoothed;

	logic [dema_pkg::ACC_W:0]           acc_rnd;
	logic [dema_pkg::SAMPLE_W:0]        acc_shift;
	logic [dema_pkg::SAMPLE_W-1:0]      direct_y;
	logic [dema_pkg::NUM_W-1:0]         num;
	logic [REM_W-1:0]                   rem_init;
	logic [dema_pkg::P_W:0]             trial;
	logic                               trial_ge;
	logic [dema_pkg::SAMPLE_W-1:0]      quo_ext;
	logic [dema_pkg::SAMPLE_W-1:0]      div_y;

	assign out_free = !out_valid_q || out_ready;

	// direct path: average rounded half up to the sample format, saturated
	always_comb begin
		acc_rnd   = {q_entry.acc[dema_pkg::ACC_W-1], q_entry.acc} + RND_OUT;
		acc_shift = acc_rnd[dema_pkg::ACC_W:dema_pkg::WFB];
		if (acc_shift[dema_pkg::SAMPLE_W] == acc_shift[dema_pkg::SAMPLE_W-1]) begin
			direct_y = acc_shift[dema_pkg::SAMPLE_W-1:0];
		end else if (acc_shift[dema_pkg::SAMPLE_W]) begin
			direct_y = dema_pkg::SAMPLE_MIN;
		end else begin
			direct_y = dema_pkg::SAMPLE_MAX;
		end
	end

	// divider: numerator with rounding bias, then one quotient bit per cycle
	always_comb begin
		num = {mag_q, {(dema_pkg::NUM_W-dema_pkg::ACC_W){1'b0}}}
			+ {{(dema_pkg::NUM_W-dema_pkg::P_W+1){1'b0}}, denom_q[dema_pkg::P_W-1:1]};
		rem_init = num[dema_pkg::NUM_W-1:dema_pkg::DIV_STEPS];
		trial    = {rem_q, num_lo_q[dema_pkg::DIV_STEPS-1]} - {1'b0, denom_q};
		trial_ge = ({rem_q, num_lo_q[dema_pkg::DIV_STEPS-1]} >= {1'b0, denom_q});
		quo_ext  = {1'b0, quo_q};
		if (ovf_q) begin
			div_y = neg_q ? dema_pkg::SAMPLE_MIN : dema_pkg::SAMPLE_MAX;
		end else begin
			div_y = neg_q ? (~quo_ext + 1'b1) : quo_ext;
		end
	end

	// sequencer
	always_comb begin
		state_d      = state_q;
		q_pop        = 1'b0;
		write_out    = 1'b0;
		new_value    = direct_y;
		new_smoothed = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					case (q_entry.kind)
						dema_pkg::KIND_DIVIDE: begin
							q_pop   = 1'b1;
							state_d = ST_LOAD;
						end
						dema_pkg::KIND_DIRECT: begin
							if (out_free) begin
								q_pop     = 1'b1;
								write_out = 1'b1;
							end
						end
						default: begin
							if (out_free) begin
								q_pop        = 1'b1;
								write_out    = 1'b1;
								new_value    = q_entry.acc[dema_pkg::SAMPLE_W-1:0];
								new_smoothed = 1'b0;
							end
						end
					endcase
				end
			end
			ST_LOAD: begin
				state_d = (rem_init >= denom_q) ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				new_value = div_y;
				if (out_free) begin
					write_out = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_pop && q_entry.kind == dema_pkg::KIND_DIVIDE) begin
			neg_q   <= q_entry.acc[dema_pkg::ACC_W-1];
			mag_q   <= q_entry.acc[dema_pkg::ACC_W-1] ? (~q_entry.acc + 1'b1) : q_entry.acc;
			denom_q <= q_entry.denom;
		end
		if (state_q == ST_LOAD) begin
			ovf_q    <= (rem_init >= denom_q);
			rem_q    <= rem_init[dema_pkg::P_W-1:0];
			num_lo_q <= num[dema_pkg::DIV_STEPS-1:0];
			quo_q    <= '0;
			cnt_q    <= dema_pkg::CNT_W'(dema_pkg::DIV_STEPS - 1);
		end
		if (state_q == ST_DIV) begin
			rem_q    <= trial_ge ? trial[dema_pkg::P_W-1:0]
				: {rem_q[dema_pkg::P_W-2:0], num_lo_q[dema_pkg::DIV_STEPS-1]};
			num_lo_q <= {num_lo_q[dema_pkg::DIV_STEPS-2:0], 1'b0};
			quo_q    <= {quo_q[dema_pkg::DIV_STEPS-2:0], trial_ge};
			cnt_q    <= cnt_q - 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (write_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (write_out) begin
			out_value_q    <= new_value;
			out_smoothed_q <= new_smoothed;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_value    = out_value_q;
	assign out_smoothed = out_smoothed_q;

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from an empty queue");

	a_rem_below_denom: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < denom_q))
		else $error("divider remainder not below divisor");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q < dema_pkg::CNT_W'(dema_pkg::DIV_STEPS)))
		else $error("divider step count out of range");

endmodule

@@ rtl/core/debiased_ema_smoother_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debiased_ema_smoother_core: debiased exponential moving average
// Smooths Q16.16 samples with a programmable weight, divides out the start-up
// bias and passes flagged samples through unchanged.
// ----------------------------------------------------------------------------
//
// channel   dir  beat contents
// s_axis    in   tdata: sample_value[31:0]; tuser: sample_invalid, series_constant
// m_axis    out  tdata: out_value[31:0]; tuser: was_smoothed
// cfg       in   cfg_wr_data: smoothing_weight[16:0], written when cfg_wr_en
//
// The front takes no new beat until the last has left its multiply stage
// (multiply stage, then state update). The back emits pass-through and
// weight-one beats directly; a debiased beat goes through the bit-serial divider
// (pop, load with rounding bias, 31 quotient bits, output), which sets the rate.
// A two-entry queue lets the front keep accepting while the divider works.
// Reset is asynchronous and clears weight, average and power; there is no
// clearing pass. A stalled m_axis holds its beat while the back keeps going.
//
module debiased_ema_smoother_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [16:0] cfg_wr_data,     // smoothing_weight
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,    // sample_value
	input  logic [1:0]  s_axis_tuser,    // sample_invalid, series_constant
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,    // out_value
	output logic [0:0]  m_axis_tuser     // was_smoothed
);

	logic                   q_push;
	logic                   q_pop;
	logic                   q_full;
	logic                   q_empty;
	dema_pkg::queue_entry_t push_entry;
	dema_pkg::queue_entry_t pop_entry;

	// input side: classification and state update
	dema_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_value    (s_axis_tdata),
		.in_invalid  (s_axis_tuser[0]),
		.in_constant (s_axis_tuser[1]),
		.q_push      (q_push),
		.q_entry     (push_entry),
		.q_full      (q_full)
	);

	// decoupling queue
	dema_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.pop_entry  (pop_entry),
		.empty      (q_empty)
	);

	// output side: debias divide and output register
	dema_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_entry      (pop_entry),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_value    (m_axis_tdata),
		.out_smoothed (m_axis_tuser[0])
	);

endmodule

@@ sim/debiased_ema_smoother_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debiased_ema_smoother_core_tb: self-checking bench for the ema smoother
// Drives samples and weight writes, and keeps its own bit-exact copy of the
// average, power and weight to predict every output beat. Output beats are
// compared in order, with random gaps on both streams and a long hold-off.
// ----------------------------------------------------------------------------
module debiased_ema_smoother_core_tb;
	import dema_pkg::*;

	localparam int          TUSER_INVALID  = 0;
	localparam int          TUSER_CONSTANT = 1;
	localparam int unsigned SETTLE_CYCLES  = 64;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned MAX_REPORTS    = 10;

	localparam logic signed [79:0] ACC_HI  = (80'sd1 <<< (ACC_W - 1)) - 80'sd1;
	localparam logic signed [79:0] ACC_LO  = -(80'sd1 <<< (ACC_W - 1));
	localparam logic signed [79:0] SMP_HI  = (80'sd1 <<< (SAMPLE_W - 1)) - 80'sd1;
	localparam logic signed [79:0] SMP_LO  = -(80'sd1 <<< (SAMPLE_W - 1));
	localparam logic signed [79:0] HALF_W  = 80'sd1 <<< (WFB - 1);
	localparam logic signed [79:0] ONE_W   = 80'sd1 <<< WFB;

	typedef struct packed {
		logic [31:0] value;
		logic        smoothed;
	} ema_beat_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [16:0] cfg_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;     // sample_value
	logic [1:0]  s_axis_tuser;     // sample_invalid, series_constant
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;     // out_value
	logic [0:0]  m_axis_tuser;     // was_smoothed

	// predictor state
	logic signed [47:0] ema_model   = '0;
	logic [32:0]        power_model = P_ONE;
	logic [16:0]        weight_model = '0;

	ema_beat_t   pending_ema_beats[$];
	int unsigned mismatch_count = 0;
	int unsigned idle_cycles    = 0;
	bit          tx_idle_en     = 1'b1;
	bit          rx_idle_en     = 1'b1;
	bit          hold_off_req   = 1'b0;

	debiased_ema_smoother_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// clock, 10 ns period
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// one step of the debiased average; returns 0 when the block is disabled
	function automatic bit ema_predict(input logic [31:0] x_raw, input logic flag_inv,
			input logic flag_const, output ema_beat_t beat);
		logic signed [79:0] xs;
		logic signed [79:0] wt;
		logic signed [79:0] acc;
		logic signed [79:0] sum;
		logic signed [79:0] neg_acc;
		logic signed [79:0] y;
		logic [63:0]        pw;
		logic [63:0]        mag;
		logic [63:0]        denom;
		logic [63:0]        quot;
		bit                 neg;
		beat = '0;
		if (weight_model == '0)
			return 1'b0;
		if (flag_inv || flag_const) begin
			beat.value    = x_raw;
			beat.smoothed = 1'b0;
			return 1'b1;
		end
		xs  = {{48{x_raw[31]}}, x_raw};
		wt  = {63'b0, weight_model};
		acc = {{32{ema_model[47]}}, ema_model};

		// average update, product rounded half up, then 48-bit saturation
		sum = ((acc * wt + HALF_W) >>> WFB) + (ONE_W - wt) * xs;
		if (sum > ACC_HI)
			ema_model = ACC_HI[47:0];
		else if (sum < ACC_LO)
			ema_model = ACC_LO[47:0];
		else
			ema_model = sum[47:0];

		// running power of the weight
		pw          = {31'b0, power_model} * {47'b0, weight_model} + 64'd32768;
		power_model = pw[WFB +: 33];

		// debias, or plain rounding when the weight is one or the power has reached one
		acc = {{32{ema_model[47]}}, ema_model};
		if (weight_model == W_ONE || power_model >= P_ONE) begin
			y = (acc + HALF_W) >>> WFB;
		end else begin
			denom   = {31'b0, P_ONE} - {31'b0, power_model};
			neg     = ema_model[47];
			neg_acc = -acc;
			mag     = neg ? neg_acc[63:0] : acc[63:0];
			quot    = ((mag << (32 - WFB)) + (denom >> 1)) / denom;
			if (quot > 64'h1_0000_0000)
				quot = 64'h1_0000_0000;
			y = neg ? -$signed({16'b0, quot}) : $signed({16'b0, quot});
		end
		if (y > SMP_HI)
			y = SMP_HI;
		else if (y < SMP_LO)
			y = SMP_LO;
		beat.value    = y[31:0];
		beat.smoothed = 1'b1;
		return 1'b1;
	endfunction

	// prediction on accepted input beats, checking on accepted output beats
	always @(posedge clk) begin
		ema_beat_t predicted;
		ema_beat_t wanted;
		if (s_axis_tvalid && s_axis_tready) begin
			if (ema_predict(s_axis_tdata, s_axis_tuser[TUSER_INVALID],
					s_axis_tuser[TUSER_CONSTANT], predicted))
				pending_ema_beats.push_back(predicted);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_ema_beats.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: unexpected output beat value=%h smoothed=%b",
						$realtime, m_axis_tdata, m_axis_tuser[0]);
			end else begin
				wanted = pending_ema_beats.pop_front();
				if (m_axis_tdata !== wanted.value || m_axis_tuser[0] !== wanted.smoothed) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: beat mismatch value exp=%h act=%h smoothed exp=%b act=%b",
							$realtime, wanted.value, m_axis_tdata, wanted.smoothed,
							m_axis_tuser[0]);
				end
			end
		end
	end

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** debiased_ema_smoother_core: FAILED **");
			$finish;
		end
	end

	// output side ready: random stall bursts and one long hold-off on request
	initial begin
		int unsigned stall;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 14);
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// one input beat, with an optional gap in front of it
	task automatic send_sample(input logic [31:0] value, input logic flag_inv,
			input logic flag_const);
		int unsigned gap;
		@(negedge clk);
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tuser  <= {flag_const, flag_inv};
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
	endtask

	task automatic send_random_sample();
		logic [31:0] value;
		case ($urandom_range(0, 9))
			0:       value = SAMPLE_MAX;
			1:       value = SAMPLE_MIN;
			2, 3:    value = $urandom_range(0, 1 << 20);
			4:       value = -$urandom_range(0, 1 << 20);
			default: value = $urandom;
		endcase
		send_sample(value, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
	endtask

	// weight write once everything in flight has come out
	task automatic write_weight(input logic [16:0] value);
		logic [16:0] clipped;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_ema_beats.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		clipped = (value > W_ONE) ? W_ONE : value;
		if (clipped != weight_model) begin
			weight_model = clipped;
			ema_model    = '0;
			power_model  = P_ONE;
		end
	endtask

	// weight zero after reset: nothing comes out
	task automatic test_disabled_after_reset();
		send_sample(32'h0001_0000, 1'b0, 1'b0);
		send_sample(SAMPLE_MIN, 1'b1, 1'b0);
		send_sample(SAMPLE_MAX, 1'b0, 1'b1);
	endtask

	// weight one, written above range so it clips; average stays zero
	task automatic test_weight_one();
		write_weight(17'h1FFFF);
		send_sample(SAMPLE_MAX, 1'b0, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0, 1'b0);
		write_weight(17'h10001);
		send_sample(32'h0003_8000, 1'b0, 1'b0);
	endtask

	// smallest and largest fractional weights on extreme samples
	task automatic test_extreme_weights();
		write_weight(17'd1);
		send_sample(SAMPLE_MAX, 1'b0, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0, 1'b0);
		send_sample(32'h0000_0000, 1'b0, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
		write_weight(17'd65535);
		send_sample(SAMPLE_MAX, 1'b0, 1'b0);
		send_sample(SAMPLE_MAX, 1'b0, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0, 1'b0);
	endtask

	// flagged samples pass through and leave the average alone
	task automatic test_passthrough();
		write_weight(17'd49152);
		send_sample(32'h0010_0000, 1'b0, 1'b0);
		send_sample(SAMPLE_MIN, 1'b1, 1'b0);
		send_sample(32'hDEAD_BEEF, 1'b0, 1'b1);
		send_sample(SAMPLE_MAX, 1'b1, 1'b1);
		send_sample(32'h0010_0000, 1'b0, 1'b0);
	endtask

	// same weight again keeps the state, a new one clears it
	task automatic test_weight_rewrite();
		write_weight(17'd40000);
		send_sample(32'h0020_0000, 1'b0, 1'b0);
		write_weight(17'd40000);
		send_sample(32'h0020_0000, 1'b0, 1'b0);
		write_weight(17'd40001);
		send_sample(32'hFFE0_0000, 1'b0, 1'b0);
	endtask

	// long output hold-off while the input keeps offering beats
	task automatic test_backpressure();
		write_weight(17'd30000);
		tx_idle_en   = 1'b0;
		hold_off_req = 1'b1;
		repeat (20) send_random_sample();
		tx_idle_en = 1'b1;
	endtask

	// random samples over a spread of weights, disabled phase included
	task automatic test_random_weights();
		logic [16:0] weight;
		for (int phase = 0; phase < 12; phase++) begin
			case (phase)
				0:       weight = 17'd65535;
				1:       weight = 17'd1;
				2:       weight = W_ONE;
				3:       weight = 17'd32768;
				4:       weight = 17'($urandom_range(2, 1000));
				5:       weight = 17'($urandom_range(60000, 65535));
				6:       weight = 17'd0;
				7:       weight = 17'($urandom_range(65537, 131071));
				default: weight = 17'($urandom_range(1, 65535));
			endcase
			write_weight(weight);
			repeat ((weight == '0) ? 10 : 50) send_random_sample();
		end
	endtask

	// closing stretch with no gaps or stalls on either side
	task automatic test_full_rate_tail();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		write_weight(17'($urandom_range(50000, 65535)));
		repeat (100) send_random_sample();
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_disabled_after_reset();
		test_weight_one();
		test_extreme_weights();
		test_passthrough();
		test_weight_rewrite();
		test_backpressure();
		test_random_weights();
		test_full_rate_tail();

		// drain, then let any late beat show up
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_ema_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		mismatch_count += pending_ema_beats.size();
		if (mismatch_count == 0)
			$display("** debiased_ema_smoother_core: PASSED **");
		else
			$display("** debiased_ema_smoother_core: FAILED **");
		$finish;
	end

endmodule
